/* src/mfpr_pkg.sv */
// ---------------------------------------------------------------------------
// mfpr_pkg
// Shared codes, select encodings and the command/status bundles that pass
// between the push-relabel controller and its datapath.
// ---------------------------------------------------------------------------
package mfpr_pkg;

  localparam int FLOW_TOTAL_W = 22;
  localparam int CFG_W        = 7;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_SINK       = 2'd2;

  typedef enum logic [2:0] {
    FLOW_ZERO,
    FLOW_CAP,
    FLOW_NEGCAP,
    FLOW_NEW,
    FLOW_NEGNEW
  } flow_wsel_t;

  typedef enum logic [1:0] {
    EXC_ZERO,
    EXC_CAP,
    EXC_HELD,
    EXC_ADD
  } exc_wsel_t;

  typedef enum logic [1:0] {
    HGT_ZERO,
    HGT_NODES,
    HGT_BEST
  } hgt_wsel_t;

  typedef struct packed {
    logic       cap_we;
    logic       rd_en;
    logic       flow_we;
    flow_wsel_t flow_wsel;
    logic       exc_we;
    exc_wsel_t  exc_wsel;
    logic       hgt_we;
    hgt_wsel_t  hgt_wsel;
    logic       al_we;
    logic       lat_node;
    logic       push_eval;
    logic       j_ne_i;
    logic       top_from_hgt;
    logic       top_from_best;
    logic       total_clr;
    logic       total_acc;
  } cmd_t;

  typedef struct packed {
    logic exc_pos;
    logic h_gt_top;
    logic h_eq_top;
    logic adm;
    logic ex_zero;
    logic pushed;
    logic best_valid;
    logic best_gt_top;
  } sts_t;

endpackage

/* src/mfpr_dp.sv */
// ---------------------------------------------------------------------------
// mfpr_dp
// Datapath: capacity, flow, excess, height and active-list memories with
// registered reads, plus the residual / push / relabel arithmetic.
// ---------------------------------------------------------------------------
module mfpr_dp import mfpr_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int CAP_BITS  = 16,
  localparam int IW = $clog2(MAX_NODES),
  localparam int AW = 2 * IW,
  localparam int NW = IW + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [AW-1:0]           cap_waddr,
  input  logic [CAP_BITS-1:0]     cap_wdata,
  input  logic [AW-1:0]           cap_raddr,
  input  logic [AW-1:0]           flow_waddr,
  input  logic [AW-1:0]           flow_raddr,
  input  logic [IW-1:0]           node_waddr,
  input  logic [IW-1:0]           node_raddr,
  input  logic [IW-1:0]           al_waddr,
  input  logic [IW-1:0]           al_wdata,
  input  logic [IW-1:0]           al_raddr,
  input  logic [NW-1:0]           n_nodes,
  output logic [IW-1:0]           al_q,
  output logic [FLOW_TOTAL_W-1:0] total
);

  localparam int FW    = CAP_BITS + IW + 2;
  localparam int HW    = IW + 2;
  localparam int DEPTH = 1 << AW;
  localparam int NDEP  = 1 << IW;

  logic [CAP_BITS-1:0]  cap_mem  [DEPTH];
  logic signed [FW-1:0] flow_mem [DEPTH];
  logic signed [FW-1:0] exc_mem  [NDEP];
  logic [HW-1:0]        hgt_mem  [NDEP];
  logic [IW-1:0]        al_mem   [NDEP];

  logic [CAP_BITS-1:0]  cap_q;
  logic signed [FW-1:0] flow_q;
  logic signed [FW-1:0] exc_q;
  logic [HW-1:0]        hgt_q;

  logic signed [FW-1:0] ex_r, amt_r, fnew_r;
  logic [HW-1:0]        hi_r, top_h_r;
  logic [HW:0]          best_r;
  logic                 best_valid_r, pushed_r;
  logic [FLOW_TOTAL_W-1:0] total_r;

  logic signed [FW-1:0] cap_ext, amt, fnew, flow_wdata, exc_wdata;
  logic signed [FW:0]   resid, ex_ext;
  logic [HW:0]          hj1;
  logic [HW-1:0]        hgt_wdata;
  logic                 adm, best_upd;

  assign cap_ext = FW'({1'b0, cap_q});
  assign resid   = {cap_ext[FW-1], cap_ext} - {flow_q[FW-1], flow_q};
  assign ex_ext  = {ex_r[FW-1], ex_r};
  assign amt     = (resid < ex_ext) ? resid[FW-1:0] : ex_r;
  assign fnew    = flow_q + amt;
  assign hj1     = {1'b0, hgt_q} + (HW+1)'(1);
  assign adm     = cmd.j_ne_i && ({1'b0, hi_r} == hj1) && (resid > 0);
  assign best_upd = cmd.j_ne_i && (resid > 0) && (!best_valid_r || hj1 < best_r);

  always_comb begin
    case (cmd.flow_wsel)
      FLOW_CAP:    flow_wdata = cap_ext;
      FLOW_NEGCAP: flow_wdata = -cap_ext;
      FLOW_NEW:    flow_wdata = fnew;
      FLOW_NEGNEW: flow_wdata = -fnew_r;
      default:     flow_wdata = '0;
    endcase
    case (cmd.exc_wsel)
      EXC_CAP:  exc_wdata = cap_ext;
      EXC_HELD: exc_wdata = ex_r;
      EXC_ADD:  exc_wdata = exc_q + amt_r;
      default:  exc_wdata = '0;
    endcase
    case (cmd.hgt_wsel)
      HGT_NODES: hgt_wdata = HW'(n_nodes);
      HGT_BEST:  hgt_wdata = best_r[HW-1:0];
      default:   hgt_wdata = '0;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.cap_we) cap_mem[cap_waddr] <= cap_wdata;
    if (cmd.flow_we) flow_mem[flow_waddr] <= flow_wdata;
    if (cmd.exc_we) exc_mem[node_waddr] <= exc_wdata;
    if (cmd.hgt_we) hgt_mem[node_waddr] <= hgt_wdata;
    if (cmd.al_we) al_mem[al_waddr] <= al_wdata;
    if (cmd.rd_en) begin
      cap_q  <= cap_mem[cap_raddr];
      flow_q <= flow_mem[flow_raddr];
      exc_q  <= exc_mem[node_raddr];
      hgt_q  <= hgt_mem[node_raddr];
      al_q   <= al_mem[al_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      pushed_r     <= 1'b0;
      total_r      <= '0;
    end else begin
      if (cmd.lat_node) begin
        best_valid_r <= 1'b0;
        pushed_r     <= 1'b0;
      end else if (cmd.push_eval) begin
        if (adm) pushed_r <= 1'b1;
        if (best_upd) best_valid_r <= 1'b1;
      end
      if (cmd.total_clr) total_r <= '0;
      else if (cmd.total_acc) total_r <= total_r + FLOW_TOTAL_W'(flow_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_node) begin
      ex_r <= exc_q;
      hi_r <= hgt_q;
    end else if (cmd.push_eval) begin
      if (adm) begin
        ex_r   <= ex_r - amt;
        amt_r  <= amt;
        fnew_r <= fnew;
      end
      if (best_upd) best_r <= hj1;
    end
    if (cmd.top_from_hgt) top_h_r <= hgt_q;
    else if (cmd.top_from_best) top_h_r <= best_r[HW-1:0];
  end

  assign sts.exc_pos     = exc_q > 0;
  assign sts.h_gt_top    = hgt_q > top_h_r;
  assign sts.h_eq_top    = hgt_q == top_h_r;
  assign sts.adm         = adm;
  assign sts.ex_zero     = ex_r == 0;
  assign sts.pushed      = pushed_r;
  assign sts.best_valid  = best_valid_r;
  assign sts.best_gt_top = best_r > {1'b0, top_h_r};

  assign total = total_r;

endmodule

/* src/mfpr_ctrl.sv */
// ---------------------------------------------------------------------------
// mfpr_ctrl
// Sequencer for the solver: matrix clear sweep, run set-up, active node
// scan, discharge (push / relabel) and the final flow sum.
// ---------------------------------------------------------------------------
module mfpr_ctrl import mfpr_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int CAP_BITS  = 16,
  localparam int IW = $clog2(MAX_NODES),
  localparam int AW = 2 * IW,
  localparam int NW = IW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [5:0]          in_from_node,
  input  logic [5:0]          in_to_node,
  input  logic [15:0]         in_capacity,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output cmd_t                cmd,
  input  sts_t                sts,
  output logic [AW-1:0]       cap_waddr,
  output logic [CAP_BITS-1:0] cap_wdata,
  output logic [AW-1:0]       cap_raddr,
  output logic [AW-1:0]       flow_waddr,
  output logic [AW-1:0]       flow_raddr,
  output logic [IW-1:0]       node_waddr,
  output logic [IW-1:0]       node_raddr,
  output logic [IW-1:0]       al_waddr,
  output logic [IW-1:0]       al_wdata,
  output logic [IW-1:0]       al_raddr,
  output logic [NW-1:0]       n_nodes,
  input  logic [IW-1:0]       al_q
);

  typedef enum logic [4:0] {
    S_CLR_CAP, S_IDLE, S_FCLR, S_NINIT, S_SAT_RD, S_SAT_WR, S_SAT_WR2,
    S_SCAN_RD, S_SCAN_EV, S_DIS_RD, S_DIS_I, S_DIS_EH, S_PS_RD, S_PS_EV,
    S_PS_W2, S_PS_W3, S_PS_END, S_SUM_RD, S_SUM_AC, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [IW-1:0]    row_r, row_nxt, j_r, j_nxt, i_r, i_nxt, list0_r, list0_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt, n_r, n_nxt, cnt_v, n_sat;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] node_count_r;
  logic [5:0]       source_r, sink_r;

  logic [IW-1:0] s_idx, t_idx;
  logic          last_j, last_row, run_bad, consider;

  assign s_idx    = IW'(source_r);
  assign t_idx    = IW'(sink_r);
  assign last_j   = {1'b0, j_r} == NW'(n_r - NW'(1));
  assign last_row = {1'b0, row_r} == NW'(n_r - NW'(1));
  assign consider = (j_r != s_idx) && (j_r != t_idx) && sts.exc_pos;

  always_comb begin
    if (int'(node_count_r) < 2) n_sat = NW'(2);
    else if (int'(node_count_r) > MAX_NODES) n_sat = NW'(MAX_NODES);
    else n_sat = NW'(node_count_r);
  end

  assign run_bad = (int'(source_r) >= int'(n_sat)) || (int'(sink_r) >= int'(n_sat))
                   || (source_r == sink_r);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    row_nxt       = row_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    list0_nxt     = list0_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    cnt_v         = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    cap_waddr     = addr_r;
    cap_wdata     = '0;
    cap_raddr     = {i_r, j_r};
    flow_waddr    = {row_r, j_r};
    flow_raddr    = {i_r, j_r};
    node_waddr    = j_r;
    node_raddr    = j_r;
    al_waddr      = '0;
    al_wdata      = j_r;
    al_raddr      = IW'(cnt_r - NW'(1));
    case (state_r)
      S_CLR_CAP: begin
        cmd.cap_we = 1'b1;
        addr_nxt   = addr_r + AW'(1);
        if (addr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_WRITE: begin
              cap_waddr = {IW'(in_from_node), IW'(in_to_node)};
              cap_wdata = CAP_BITS'(in_capacity);
              cmd.cap_we = (int'(in_from_node) < MAX_NODES) &&
                           (int'(in_to_node) < MAX_NODES);
            end
            FUNC_RUN: begin
              cmd.total_clr = 1'b1;
              n_nxt = n_sat;
              row_nxt = '0;
              j_nxt = '0;
              if (run_bad) begin
                out_valid_nxt = 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FCLR;
              end
            end
            FUNC_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = S_CLR_CAP;
            end
            default: ;
          endcase
        end
      end
      S_FCLR: begin
        cmd.flow_we = 1'b1;
        cmd.flow_wsel = FLOW_ZERO;
        if (last_j) begin
          j_nxt = '0;
          row_nxt = row_r + IW'(1);
          if (last_row) state_nxt = S_NINIT;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_NINIT: begin
        cmd.exc_we = 1'b1;
        cmd.exc_wsel = EXC_ZERO;
        cmd.hgt_we = 1'b1;
        cmd.hgt_wsel = (j_r == s_idx) ? HGT_NODES : HGT_ZERO;
        if (last_j) begin
          j_nxt = '0;
          state_nxt = S_SAT_RD;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_SAT_RD: begin
        if (j_r == s_idx) begin
          if (last_j) begin
            j_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_SCAN_RD;
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end else begin
          cmd.rd_en = 1'b1;
          cap_raddr = {s_idx, j_r};
          state_nxt = S_SAT_WR;
        end
      end
      S_SAT_WR: begin
        cmd.flow_we = 1'b1;
        cmd.flow_wsel = FLOW_CAP;
        flow_waddr = {s_idx, j_r};
        cmd.exc_we = 1'b1;
        cmd.exc_wsel = EXC_CAP;
        state_nxt = S_SAT_WR2;
      end
      S_SAT_WR2: begin
        cmd.flow_we = 1'b1;
        cmd.flow_wsel = FLOW_NEGCAP;
        flow_waddr = {j_r, s_idx};
        if (last_j) begin
          j_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_SCAN_RD;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = S_SAT_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (consider && (cnt_r == '0 || sts.h_gt_top)) begin
          cmd.al_we = 1'b1;
          cmd.top_from_hgt = 1'b1;
          list0_nxt = j_r;
          cnt_v = NW'(1);
        end else if (consider && sts.h_eq_top) begin
          cmd.al_we = 1'b1;
          al_waddr = IW'(cnt_r);
          cnt_v = cnt_r + NW'(1);
        end
        cnt_nxt = cnt_v;
        if (last_j) begin
          j_nxt = '0;
          state_nxt = (cnt_v == '0) ? S_SUM_RD : S_DIS_RD;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_DIS_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DIS_I;
      end
      S_DIS_I: begin
        i_nxt = al_q;
        cmd.rd_en = 1'b1;
        node_raddr = al_q;
        state_nxt = S_DIS_EH;
      end
      S_DIS_EH: begin
        cmd.lat_node = 1'b1;
        j_nxt = '0;
        state_nxt = S_PS_RD;
      end
      S_PS_RD: begin
        if (sts.ex_zero) begin
          state_nxt = S_PS_END;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_PS_EV;
        end
      end
      S_PS_EV: begin
        cmd.push_eval = 1'b1;
        cmd.j_ne_i = j_r != i_r;
        if (sts.adm) begin
          cmd.flow_we = 1'b1;
          cmd.flow_wsel = FLOW_NEW;
          flow_waddr = {i_r, j_r};
          state_nxt = S_PS_W2;
        end else if (last_j) begin
          state_nxt = S_PS_END;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = S_PS_RD;
        end
      end
      S_PS_W2: begin
        cmd.flow_we = 1'b1;
        cmd.flow_wsel = FLOW_NEGNEW;
        flow_waddr = {j_r, i_r};
        cmd.rd_en = 1'b1;
        state_nxt = S_PS_W3;
      end
      S_PS_W3: begin
        cmd.exc_we = 1'b1;
        cmd.exc_wsel = EXC_ADD;
        if (last_j) begin
          state_nxt = S_PS_END;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = S_PS_RD;
        end
      end
      S_PS_END: begin
        node_waddr = i_r;
        if (sts.pushed) begin
          cmd.exc_we = 1'b1;
          cmd.exc_wsel = EXC_HELD;
          if (sts.ex_zero) cnt_v = cnt_r - NW'(1);
        end else if (!sts.best_valid) begin
          // no residual edge at all: excess is dropped
          cmd.exc_we = 1'b1;
          cmd.exc_wsel = EXC_ZERO;
          cnt_v = cnt_r - NW'(1);
        end else begin
          cmd.hgt_we = 1'b1;
          cmd.hgt_wsel = HGT_BEST;
          if (i_r == list0_r) cmd.top_from_best = 1'b1;
          else if (sts.best_gt_top) cnt_v = '0;
        end
        cnt_nxt = cnt_v;
        j_nxt = '0;
        state_nxt = (cnt_v != '0) ? S_DIS_RD : S_SCAN_RD;
      end
      S_SUM_RD: begin
        cmd.rd_en = 1'b1;
        flow_raddr = {s_idx, j_r};
        state_nxt = S_SUM_AC;
      end
      S_SUM_AC: begin
        cmd.total_acc = j_r != s_idx;
        if (last_j) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          j_nxt = j_r + IW'(1);
          state_nxt = S_SUM_RD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR_CAP;
      addr_r       <= '0;
      row_r        <= '0;
      j_r          <= '0;
      i_r          <= '0;
      list0_r      <= '0;
      cnt_r        <= '0;
      n_r          <= NW'(2);
      out_valid_r  <= 1'b0;
      node_count_r <= CFG_W'(2);
      source_r     <= 6'd0;
      sink_r       <= 6'd1;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      row_r       <= row_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
      list0_r     <= list0_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_wdata;
          CFG_SOURCE:     source_r <= cfg_wdata[5:0];
          CFG_SINK:       sink_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign n_nodes   = n_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_r) else $error("active count beyond node count");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_OUT)) else $error("result valid outside output state");

  a_push_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PS_EV) && sts.adm |=> state_r == S_PS_W2)
    else $error("push not followed by reverse flow write");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r && cnt_r <= n_r)
    else $error("input taken while result pending");

endmodule

/* src/max_flow_push_relabel_core.sv */
// ---------------------------------------------------------------------------
// max_flow_push_relabel_core
// Maximum flow over a dense capacity matrix, push-relabel, highest label.
//
// Input channel (in_valid/in_ready): func 0 writes one capacity entry;
// func 2 clears the whole capacity matrix; func 1 runs the solver and
// yields one item on the result channel (out_valid/out_ready). A run
// clears the flow matrix, sets up heights and excesses and saturates the
// source edges, then repeats an active node scan and discharge passes
// (push / relabel) and ends with the sum of the flow out of the source. A
// run with a bad source or sink goes straight to the result with a total
// of zero. One item is worked on at a time; in_ready is low while busy.
// After reset the capacity matrix is cleared before the first item is
// taken; configuration writes are taken at any time.
// A result is held on out_flow_total until out_ready; no new item is taken
// until it leaves.
// ---------------------------------------------------------------------------
module max_flow_push_relabel_core import mfpr_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int CAP_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [5:0]              in_from_node,
  input  logic [5:0]              in_to_node,
  input  logic [15:0]             in_capacity,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FLOW_TOTAL_W-1:0] out_flow_total,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int AW = 2 * IW;
  localparam int NW = IW + 1;

  cmd_t                cmd;
  sts_t                sts;
  logic [AW-1:0]       cap_waddr, cap_raddr, flow_waddr, flow_raddr;
  logic [CAP_BITS-1:0] cap_wdata;
  logic [IW-1:0]       node_waddr, node_raddr, al_waddr, al_wdata, al_raddr, al_q;
  logic [NW-1:0]       n_nodes;

  mfpr_ctrl #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_from_node, .in_to_node,
    .in_capacity, .out_valid, .out_ready, .cfg_we, .cfg_index, .cfg_wdata,
    .cmd, .sts, .cap_waddr, .cap_wdata, .cap_raddr, .flow_waddr, .flow_raddr,
    .node_waddr, .node_raddr, .al_waddr, .al_wdata, .al_raddr, .n_nodes, .al_q
  );

  mfpr_dp #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cap_waddr, .cap_wdata, .cap_raddr,
    .flow_waddr, .flow_raddr, .node_waddr, .node_raddr, .al_waddr, .al_wdata,
    .al_raddr, .n_nodes, .al_q, .total(out_flow_total)
  );

endmodule
